FILE: rtl/float_integer_power_macros.svh
// Assertion macros shared by the float_integer_power RTL.
// Needs nothing else; the files that assert include it by name.
`ifndef FLOAT_INTEGER_POWER_MACROS_SVH
`define FLOAT_INTEGER_POWER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("float_integer_power: check failed");

// The consequent must hold in the cycle after the antecedent.
`define FIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("float_integer_power: check failed");

`endif

FILE: rtl/fip_pkg.sv
// Types and constants for the float_integer_power block.
// Has no dependencies; fip_unit and float_integer_power import it.
`default_nettype none
package fip_pkg;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;
    localparam logic [31:0] QBIT    = 32'h0040_0000;

    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } t_fu_op;

    typedef struct packed {
        logic        start;
        t_fu_op      op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_fu_rsp;

    typedef enum logic [1:0] {
        US_IDLE,
        US_PRE,
        US_DIV,
        US_NORM
    } t_ustate;

    typedef enum logic [3:0] {
        T_IDLE,
        T_SCAN,
        T_SQ,
        T_SQW,
        T_MUL,
        T_MULW,
        T_RCP,
        T_RCPW,
        T_OUT
    } t_tstate;

endpackage
`default_nettype wire

FILE: rtl/fip_if.sv
// Valid/ready channel interfaces for the float_integer_power block.
// Standalone; used by the top level ports.
`default_nettype none
interface fip_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] base_bits;
    logic signed [31:0] exponent;

    modport source (output valid, output base_bits, output exponent, input ready);
    modport sink (input valid, input base_bits, input exponent, output ready);
endinterface

interface fip_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface
`default_nettype wire

FILE: rtl/fip_unit.sv
// Shared single-precision unit: rounded multiply and iterative reciprocal.
// Depends on fip_pkg for the request and response types.
`default_nettype none
module fip_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fip_pkg::t_fu_req i_req,
    output fip_pkg::t_fu_rsp o_rsp
);
    import fip_pkg::*;

    t_ustate            r_state;
    t_ustate            n_state;
    logic               r_done;
    logic        [31:0] r_res;
    logic               r_s;
    logic signed [10:0] r_e;
    logic        [47:0] r_sig;
    logic               r_sticky;
    logic        [23:0] r_div;
    logic        [24:0] r_rem;
    logic        [25:0] r_q;
    logic        [4:0]  r_cnt;

    logic        [7:0]  ea;
    logic        [7:0]  eb;
    logic        [7:0]  ea_adj;
    logic        [7:0]  eb_adj;
    logic        [23:0] ma;
    logic        [23:0] mb;
    logic               nan_a;
    logic               nan_b;
    logic               inf_a;
    logic               inf_b;
    logic               zero_a;
    logic               zero_b;
    logic               sx;

    logic               qbit;
    logic        [24:0] rem_t;
    logic        [25:0] q_next;

    logic               norm_left;
    logic               norm_right;
    logic               inc;
    logic        [24:0] m25;
    logic signed [10:0] e2;
    logic        [31:0] rnd_res;

    assign ea     = i_req.a[30:23];
    assign eb     = i_req.b[30:23];
    assign ea_adj = (ea == 8'd0) ? 8'd1 : ea;
    assign eb_adj = (eb == 8'd0) ? 8'd1 : eb;
    assign ma     = {ea != 8'd0, i_req.a[22:0]};
    assign mb     = {eb != 8'd0, i_req.b[22:0]};
    assign nan_a  = (ea == 8'hFF) && (i_req.a[22:0] != 23'd0);
    assign nan_b  = (eb == 8'hFF) && (i_req.b[22:0] != 23'd0);
    assign inf_a  = (ea == 8'hFF) && (i_req.a[22:0] == 23'd0);
    assign inf_b  = (eb == 8'hFF) && (i_req.b[22:0] == 23'd0);
    assign zero_a = (i_req.a[30:0] == 31'd0);
    assign zero_b = (i_req.b[30:0] == 31'd0);
    assign sx     = i_req.a[31] ^ i_req.b[31];

    assign qbit   = (r_rem >= {1'b0, r_div});
    assign rem_t  = qbit ? (r_rem - {1'b0, r_div}) : r_rem;
    assign q_next = {r_q[24:0], qbit};

    assign norm_left  = !r_sig[47] && (r_e > 11'sd1);
    assign norm_right = (r_e < 11'sd1);
    assign inc        = r_sig[23] && ((|r_sig[22:0]) || r_sticky || r_sig[24]);
    assign m25        = {1'b0, r_sig[47:24]} + {24'd0, inc};
    assign e2         = m25[24] ? (r_e + 11'sd1) : r_e;

    always_comb begin
        if (e2 >= 11'sd255) begin
            rnd_res = {r_s, 8'hFF, 23'd0};
        end else if (m25[24]) begin
            rnd_res = {r_s, e2[7:0], 23'd0};
        end else if (m25[23]) begin
            rnd_res = {r_s, e2[7:0], m25[22:0]};
        end else begin
            rnd_res = {r_s, 8'd0, m25[22:0]};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            US_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MUL) begin
                        if (!(nan_a || nan_b || inf_a || inf_b || zero_a || zero_b)) begin
                            n_state = US_NORM;
                        end
                    end else if (!(nan_a || inf_a || zero_a)) begin
                        n_state = US_PRE;
                    end
                end
            end
            US_PRE: begin
                if (r_div[23]) begin
                    n_state = US_DIV;
                end
            end
            US_DIV: begin
                if (r_cnt == 5'd1) begin
                    n_state = US_NORM;
                end
            end
            US_NORM: begin
                if (!norm_left && !norm_right) begin
                    n_state = US_IDLE;
                end
            end
            default: n_state = US_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= US_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                US_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.op == OP_MUL) begin
                            r_done <= nan_a || nan_b || inf_a || inf_b || zero_a || zero_b;
                        end else begin
                            r_done <= nan_a || inf_a || zero_a;
                        end
                    end
                end
                US_NORM: r_done <= !norm_left && !norm_right;
                default: r_done <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            US_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MUL) begin
                        r_s      <= sx;
                        r_sig    <= ma * mb;
                        r_sticky <= 1'b0;
                        r_e      <= $signed({3'd0, ea_adj}) + $signed({3'd0, eb_adj})
                                    - 11'sd126;
                        if (nan_a) begin
                            r_res <= i_req.a | QBIT;
                        end else if (nan_b) begin
                            r_res <= i_req.b | QBIT;
                        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                            r_res <= FP_QNAN;
                        end else if (inf_a || inf_b) begin
                            r_res <= {sx, 8'hFF, 23'd0};
                        end else begin
                            r_res <= {sx, 31'd0};
                        end
                    end else begin
                        r_s      <= i_req.a[31];
                        r_div    <= ma;
                        r_e      <= $signed({3'd0, ea_adj});
                        r_sticky <= 1'b0;
                        if (nan_a) begin
                            r_res <= i_req.a | QBIT;
                        end else if (inf_a) begin
                            r_res <= {i_req.a[31], 31'd0};
                        end else begin
                            r_res <= {i_req.a[31], 8'hFF, 23'd0};
                        end
                    end
                end
            end
            US_PRE: begin
                if (r_div[23]) begin
                    r_rem <= 25'h080_0000;
                    r_q   <= 26'd0;
                    r_cnt <= 5'd26;
                    r_e   <= 11'sd254 - r_e;
                end else begin
                    r_div <= {r_div[22:0], 1'b0};
                    r_e   <= r_e - 11'sd1;
                end
            end
            US_DIV: begin
                r_q   <= q_next;
                r_rem <= {rem_t[23:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_sig    <= {q_next, 22'd0};
                    r_sticky <= (rem_t != 25'd0);
                end
            end
            US_NORM: begin
                if (norm_left) begin
                    r_sig <= {r_sig[46:0], 1'b0};
                    r_e   <= r_e - 11'sd1;
                end else if (norm_right) begin
                    if (r_e < -11'sd26) begin
                        r_sticky <= r_sticky || (|r_sig);
                        r_sig    <= 48'd0;
                        r_e      <= 11'sd1;
                    end else begin
                        r_sticky <= r_sticky || r_sig[0];
                        r_sig    <= {1'b0, r_sig[47:1]};
                        r_e      <= r_e + 11'sd1;
                    end
                end else begin
                    r_res <= rnd_res;
                end
            end
            default: r_res <= r_res;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule
`default_nettype wire

FILE: rtl/float_integer_power.sv
// Top level of float_integer_power: square-and-multiply sequencer.
// Depends on fip_pkg, fip_if, fip_unit and float_integer_power_macros.svh.
//
//   channel | dir | payload
//   i_in    | in  | base_bits[31:0], exponent[31:0] signed
//   o_out   | out | result_bits[31:0]
//
// One request scans past the leading zero bits of the exponent magnitude; then
// each bit from the leading one down costs one square and, for a set bit, one
// multiply in the shared unit. A multiply takes longer for denormal operands
// or results that need normalizing; a negative exponent adds a reciprocal.
// Reset is synchronous and returns the sequencer to idle; no clearing pass.
// A new request is taken only when the previous result has been taken.
`default_nettype none
module float_integer_power #(
    parameter int EXP_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fip_in_if.sink    i_in,
    fip_out_if.source o_out
);
    import fip_pkg::*;
    `include "float_integer_power_macros.svh"

    localparam int CNT_W = $clog2(EXP_WIDTH + 1);

    t_tstate              r_state;
    t_tstate              n_state;
    logic [31:0]          r_base;
    logic [31:0]          r_acc;
    logic [31:0]          r_result;
    logic                 r_neg;
    logic [EXP_WIDTH-1:0] r_mag;
    logic [CNT_W-1:0]     r_cnt;

    logic [EXP_WIDTH-1:0] in_raw;
    logic                 in_neg;
    logic [EXP_WIDTH-1:0] in_mag;
    logic                 accept;
    logic                 last;
    t_fu_req              fu_req;
    t_fu_rsp              fu_rsp;

    assign in_raw = i_in.exponent[EXP_WIDTH-1:0];
    assign in_neg = in_raw[EXP_WIDTH-1];
    assign in_mag = in_neg ? (~in_raw + 1'b1) : in_raw;
    assign accept = i_in.valid && i_in.ready;
    assign last   = (r_cnt == CNT_W'(1));

    assign i_in.ready        = (r_state == T_IDLE);
    assign o_out.valid       = (r_state == T_OUT);
    assign o_out.result_bits = r_result;

    fip_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fu_req),
        .o_rsp   (fu_rsp)
    );

    always_comb begin
        fu_req.start = 1'b0;
        fu_req.op    = OP_MUL;
        fu_req.a     = r_acc;
        fu_req.b     = r_acc;
        n_state      = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    n_state = (in_mag == '0) ? T_OUT : T_SCAN;
                end
            end
            T_SCAN: begin
                if (r_mag[EXP_WIDTH-1]) begin
                    n_state = T_SQ;
                end
            end
            T_SQ: begin
                fu_req.start = 1'b1;
                n_state      = T_SQW;
            end
            T_SQW: begin
                if (fu_rsp.done) begin
                    if (r_mag[EXP_WIDTH-1]) begin
                        n_state = T_MUL;
                    end else if (last) begin
                        n_state = r_neg ? T_RCP : T_OUT;
                    end else begin
                        n_state = T_SQ;
                    end
                end
            end
            T_MUL: begin
                fu_req.start = 1'b1;
                fu_req.a     = r_base;
                n_state      = T_MULW;
            end
            T_MULW: begin
                if (fu_rsp.done) begin
                    if (last) begin
                        n_state = r_neg ? T_RCP : T_OUT;
                    end else begin
                        n_state = T_SQ;
                    end
                end
            end
            T_RCP: begin
                fu_req.start = 1'b1;
                fu_req.op    = OP_RECIP;
                n_state      = T_RCPW;
            end
            T_RCPW: begin
                if (fu_rsp.done) begin
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (o_out.ready) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    r_base   <= i_in.base_bits;
                    r_neg    <= in_neg;
                    r_mag    <= in_mag;
                    r_cnt    <= CNT_W'(EXP_WIDTH);
                    r_acc    <= FP_ONE;
                    r_result <= FP_ONE;
                end
            end
            T_SCAN: begin
                if (!r_mag[EXP_WIDTH-1]) begin
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            T_SQW: begin
                if (fu_rsp.done) begin
                    r_acc <= fu_rsp.res;
                    if (!r_mag[EXP_WIDTH-1]) begin
                        r_mag    <= r_mag << 1;
                        r_cnt    <= r_cnt - CNT_W'(1);
                        r_result <= fu_rsp.res;
                    end
                end
            end
            T_MULW: begin
                if (fu_rsp.done) begin
                    r_acc    <= fu_rsp.res;
                    r_mag    <= r_mag << 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    r_result <= fu_rsp.res;
                end
            end
            T_RCPW: begin
                if (fu_rsp.done) begin
                    r_result <= fu_rsp.res;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    `FIP_ASSERT_SAME(a_out_blocks_in, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `FIP_ASSERT_SAME(a_done_when_waiting, i_clk, i_rst_n, fu_rsp.done,
        r_state == T_SQW || r_state == T_MULW || r_state == T_RCPW)
    `FIP_ASSERT_NEXT(a_zero_power_one, i_clk, i_rst_n, accept && (in_mag == '0),
        o_out.valid && (o_out.result_bits == FP_ONE))

endmodule
`default_nettype wire

FILE: tb/sv/float_integer_power_tb.sv
// Self-checking testbench for float_integer_power: directed and random bases and
// exponents, each result checked bit for bit against a software float power.
// Depends on fip_pkg, fip_if and the float_integer_power RTL.
`default_nettype none
module float_integer_power_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fip_pkg::*;

    class power_scoreboard;
        logic [31:0] expected_q[$];
        int          errors;
        int          checked;
        int          neg_exps;
        int          nan_bases;

        function automatic bit is_nan(logic [31:0] x);
            return x[30:23] == 8'hFF && x[22:0] != 0;
        endfunction

        function automatic void split(logic [31:0] x, output logic [127:0] m, output int e);
            if (x[30:23] == 0) begin
                m = x[22:0];
                e = -149;
            end else begin
                m = {1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        function automatic logic [31:0] round_pack(bit s, logic [127:0] m, int e);
            int p;
            int lsb;
            int sh;
            int be;
            logic [127:0] q;
            logic [127:0] rem;
            logic [127:0] half;
            if (m == 0) return {s, 31'b0};
            p = 127;
            while (!m[p]) p--;
            lsb = p + e - 23;
            if (lsb < -149) lsb = -149;
            sh = lsb - e;
            if (sh <= 0) begin
                q = m << (-sh);
            end else if (sh > 120) begin
                q = 0;
            end else begin
                q = m >> sh;
                rem = m & ((128'd1 << sh) - 1);
                half = 128'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
            end
            if (q[24]) begin
                q = q >> 1;
                lsb++;
            end
            if (!q[23]) return {s, 8'd0, q[22:0]};
            be = lsb + 150;
            if (be >= 255) return {s, 8'hFF, 23'd0};
            return {s, be[7:0], q[22:0]};
        endfunction

        function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            bit s;
            bit a_inf;
            bit b_inf;
            bit a_zero;
            bit b_zero;
            logic [127:0] ma;
            logic [127:0] mb;
            int ea;
            int eb;
            if (is_nan(a)) return a | QBIT;
            if (is_nan(b)) return b | QBIT;
            s = a[31] ^ b[31];
            a_inf = a[30:0] == 31'h7F80_0000;
            b_inf = b[30:0] == 31'h7F80_0000;
            a_zero = a[30:0] == 0;
            b_zero = b[30:0] == 0;
            if ((a_inf && b_zero) || (b_inf && a_zero)) return FP_QNAN;
            if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
            if (a_zero || b_zero) return {s, 31'd0};
            split(a, ma, ea);
            split(b, mb, eb);
            return round_pack(s, ma * mb, ea + eb);
        endfunction

        function automatic logic [31:0] freciprocal(logic [31:0] x);
            logic [127:0] mx;
            logic [127:0] quo;
            logic [127:0] num;
            int ex;
            if (is_nan(x)) return x | QBIT;
            if (x[30:0] == 31'h7F80_0000) return {x[31], 31'd0};
            if (x[30:0] == 0) return {x[31], 8'hFF, 23'd0};
            split(x, mx, ex);
            num = 128'd1 << 100;
            quo = num / mx;
            return round_pack(x[31], {quo[126:0], 1'b0} | 128'(num % mx != 0), -ex - 101);
        endfunction

        function automatic logic [31:0] raise(logic [31:0] base, logic [31:0] pw);
            logic [31:0] mag;
            logic [31:0] acc;
            mag = pw[31] ? -pw : pw;
            if (mag == 0) return FP_ONE;
            acc = FP_ONE;
            for (int i = 31; i >= 0; i--) begin
                acc = fmul(acc, acc);
                if (mag[i]) acc = fmul(base, acc);
            end
            return pw[31] ? freciprocal(acc) : acc;
        endfunction

        function void note(logic [31:0] base, logic [31:0] pw);
            expected_q.push_back(raise(base, pw));
            if (pw[31]) neg_exps++;
            if (is_nan(base) && pw != 0) nan_bases++;
        endfunction

        function void check(logic [31:0] got);
            logic [31:0] want;
            if (expected_q.size() == 0) begin
                $error("result_bits: no request outstanding, got %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                $error("result_bits: expected %h, got %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    fip_in_if  in_ch();
    fip_out_if out_ch();

    float_integer_power dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source)
    );

    power_scoreboard sb = new();
    int  sent;
    int  hold_request;
    bit  stall_often;
    bit  held;
    bit  drained;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.base_bits = '0;
        in_ch.exponent = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note(in_ch.base_bits, in_ch.exponent);
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.result_bits);
    end

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            out_ch.ready = 1'b0;
            hold_request--;
        end else if (stall_often) begin
            out_ch.ready = $urandom_range(0, 2) == 0;
        end else begin
            out_ch.ready = $urandom_range(0, 7) != 0;
        end
    end

    task automatic send(logic [31:0] base, logic [31:0] pw);
        in_ch.valid = 1'b1;
        in_ch.base_bits = base;
        in_ch.exponent = pw;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {1'($urandom()), 8'd0, 23'($urandom())};
            2: return {1'($urandom()), 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom())};
            3: return {1'($urandom()), 31'd0};
            default: return {1'($urandom()), 8'($urandom_range(118, 136)), 23'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] pick_exp();
        int mag;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {1'($urandom()), 31'($urandom()) >> $urandom_range(0, 30)};
            default: begin
                mag = $urandom_range(0, 300);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    logic [31:0] dir_bases[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_1234, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000,
        32'hBF80_0000, 32'h7F7F_FFFF, 32'h3FC0_0000};
    logic [31:0] dir_exps[12] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd31, 32'h7FFF_FFFF,
        32'h8000_0001, 32'h8000_0000, 32'hFFFF_FFFE, 32'd0, 32'd3, 32'hFFFF_FFFD};

    initial begin
        int burst;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int i = 0; i < 12; i++) send(dir_bases[i], dir_exps[i]);
        for (int i = 0; i < 12; i++) send(dir_bases[11 - i], dir_exps[i]);
        while (sent < 1100) begin
            stall_often = sent > 700 && sent < 900;
            if (sent >= 300 && !held) begin
                held = 1'b1;
                hold_request = 2000;
            end
            if (sent >= 600 && !drained) begin
                drained = 1'b1;
                while (sb.expected_q.size() != 0) @(negedge i_clk);
            end
            burst = $urandom_range(1, 10);
            for (int k = 0; k < burst; k++) send(pick_base(), pick_exp());
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d requests and checked %0d results (%0d negative powers, %0d NaN bases).",
            sent, sb.checked, sb.neg_exps, sb.nan_bases);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("float_integer_power_tb: done, clean");
        end else begin
            $display("float_integer_power_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("float_integer_power_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/fip_pkg.sv
rtl/fip_if.sv
rtl/fip_unit.sv
rtl/float_integer_power.sv
tb/sv/float_integer_power_tb.sv
